// ===== rtl/trilut_pkg.sv =====
// ----------------------------------------------------------------------------
// trilut_pkg
// Shared constants and codes for the trilinear table lookup block.
// ----------------------------------------------------------------------------
package trilut_pkg;

  // grid storage
  localparam int unsigned GRID_DEPTH = 4096;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned NUM_CORNER = 8;
  localparam int unsigned NUM_WORD   = 4;
  localparam int unsigned NUM_AXIS   = 3;

  // fraction of one in units of 1/65536
  localparam logic [16:0] FRAC_ONE = 17'h1_0000;

  // default grid sizes
  localparam int unsigned N_ANGLE_DEF = 16;
  localparam int unsigned N_DIST1_DEF = 16;
  localparam int unsigned N_DIST2_DEF = 16;

  // request modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_ANGLE_LOW      = 3'd0;
  localparam logic [2:0] CFG_ANGLE_INV_STEP = 3'd1;
  localparam logic [2:0] CFG_DIST1_LOW      = 3'd2;
  localparam logic [2:0] CFG_DIST1_INV_STEP = 3'd3;
  localparam logic [2:0] CFG_DIST2_LOW      = 3'd4;
  localparam logic [2:0] CFG_DIST2_INV_STEP = 3'd5;

  localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;

endpackage

// ===== rtl/trilinear_table_lookup.sv =====
// ----------------------------------------------------------------------------
// trilinear_table_lookup
// Three-dimensional grid of four Q16.16 words per point with a pipelined
// trilinear blend of the eight corners of the addressed cell.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | mode, entry_index, component, table_word,
//           |                       | angle, dist1, dist2
//  out      | out_valid / out_stall | energy, force_angle, force_dist1,
//           |                       | force_dist2, clamp_flags
//  cfg      | cfg_we                | cfg_index, cfg_wdata
//
//  one request per cycle while in_stall is low; a lookup result is presented
//  from the ninth stage register (valid as soon as its ninth stage loads)
//  the rate is set by the nine-stage pipeline with eight replicated grid read
//  ports, one per cell corner; writes update all replicas in the same stage
//  rst_n (synchronous) clears valid bits, resets config; grid is not cleared
//  a stall holds only the stages that are full, bubbles still close up
// ----------------------------------------------------------------------------
module trilinear_table_lookup
  import trilut_pkg::*;
#(
  parameter int unsigned N_ANGLE = N_ANGLE_DEF,
  parameter int unsigned N_DIST1 = N_DIST1_DEF,
  parameter int unsigned N_DIST2 = N_DIST2_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [11:0]        in_entry_index,
  input  logic [1:0]         in_component,
  input  logic signed [31:0] in_table_word,
  input  logic signed [31:0] in_angle,
  input  logic signed [31:0] in_dist1,
  input  logic signed [31:0] in_dist2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_energy,
  output logic signed [31:0] out_force_angle,
  output logic signed [31:0] out_force_dist1,
  output logic signed [31:0] out_force_dist2,
  output logic [2:0]         out_clamp_flags,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int unsigned N_AX [NUM_AXIS] = '{N_ANGLE, N_DIST1, N_DIST2};

  // blend helpers
  function automatic logic signed [48:0] lerp_a(logic signed [31:0] v0,
                                                logic signed [31:0] v1,
                                                logic [16:0] f);
    logic signed [48:0] x0, x1, w0, w1;
    x0 = 49'(v0);
    x1 = 49'(v1);
    w0 = $signed({32'd0, FRAC_ONE - f});
    w1 = $signed({32'd0, f});
    return x0 * w0 + x1 * w1;
  endfunction

  function automatic logic signed [48:0] lerp_b(logic signed [48:0] a0,
                                                logic signed [48:0] a1,
                                                logic [16:0] f);
    logic signed [65:0] x0, x1, w0, w1, s;
    x0 = 66'(a0);
    x1 = 66'(a1);
    w0 = $signed({49'd0, FRAC_ONE - f});
    w1 = $signed({49'd0, f});
    s  = x0 * w0 + x1 * w1 + 66'sd32768;
    return 49'(s >>> 16);
  endfunction

  function automatic logic signed [31:0] lerp_c(logic signed [48:0] b0,
                                                logic signed [48:0] b1,
                                                logic [16:0] f);
    logic signed [65:0] x0, x1, w0, w1, s;
    logic signed [33:0] t;
    x0 = 66'(b0);
    x1 = 66'(b1);
    w0 = $signed({49'd0, FRAC_ONE - f});
    w1 = $signed({49'd0, f});
    s  = x0 * w0 + x1 * w1 + 66'sd2147483648;
    t  = 34'(s >>> 32);
    if (t > 34'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (t < -34'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return 32'(t);
  endfunction

  // configuration registers
  logic signed [31:0] cfg_low_r [NUM_AXIS];
  logic [31:0]        cfg_inv_r [NUM_AXIS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXIS; i++) begin
        cfg_low_r[i] <= '0;
        cfg_inv_r[i] <= INV_STEP_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_LOW:      cfg_low_r[0] <= cfg_wdata;
        CFG_ANGLE_INV_STEP: cfg_inv_r[0] <= cfg_wdata;
        CFG_DIST1_LOW:      cfg_low_r[1] <= cfg_wdata;
        CFG_DIST1_INV_STEP: cfg_inv_r[1] <= cfg_wdata;
        CFG_DIST2_LOW:      cfg_low_r[2] <= cfg_wdata;
        CFG_DIST2_INV_STEP: cfg_inv_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valid bits and ready chain
  logic [9:1] v_r;
  logic [9:1] rdy;

  always_comb begin
    rdy[9] = !v_r[9] || !out_stall;
    for (int k = 8; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  // write fields travel with each request up to the grid stage
  logic        mode_r  [1:5];
  logic [11:0] eidx_r  [1:5];
  logic [1:0]  comp_r  [1:5];
  logic [31:0] word_r  [1:5];

  // per-axis pipeline payload
  logic signed [31:0] s1_x_r   [NUM_AXIS];
  logic [31:0]        s2_d_r   [NUM_AXIS];
  logic [2:0]         s2_neg_r;
  logic [63:0]        s3_p_r   [NUM_AXIS];
  logic [2:0]         s3_neg_r;
  logic [IDX_W-1:0]   s4_idx_r [NUM_AXIS];
  logic [16:0]        s4_f_r   [NUM_AXIS];
  logic [2:0]         s4_flg_r;
  logic [ADDR_W-1:0]  s5_addr_r [NUM_CORNER];
  logic [16:0]        s5_f_r   [NUM_AXIS];
  logic [2:0]         s5_flg_r;
  logic signed [31:0] s6_rd_r  [NUM_WORD][NUM_CORNER];
  logic [16:0]        s6_f_r   [NUM_AXIS];
  logic [2:0]         s6_flg_r;
  logic signed [48:0] s7_a_r   [NUM_WORD][4];
  logic [16:0]        s7_f1_r, s7_fa_r;
  logic [2:0]         s7_flg_r;
  logic signed [48:0] s8_b_r   [NUM_WORD][2];
  logic [16:0]        s8_fa_r;
  logic [2:0]         s8_flg_r;
  logic signed [31:0] s9_res_r [NUM_WORD];
  logic [2:0]         s9_flg_r;

  // combinational values of each stage
  logic signed [32:0] d_nxt   [NUM_AXIS];
  logic [63:0]        p_nxt   [NUM_AXIS];
  logic [IDX_W-1:0]   idx_nxt [NUM_AXIS];
  logic [16:0]        f_nxt   [NUM_AXIS];
  logic [2:0]         flg_nxt;
  logic [ADDR_W-1:0]  addr_nxt [NUM_CORNER];

  // offset from the first grid point
  always_comb begin
    for (int i = 0; i < NUM_AXIS; i++) begin
      d_nxt[i] = 33'(s1_x_r[i]) - 33'(cfg_low_r[i]);
    end
  end

  // scale by the inverse step, exact Q32.32
  always_comb begin
    for (int i = 0; i < NUM_AXIS; i++) begin
      p_nxt[i] = 64'(s2_d_r[i]) * 64'(cfg_inv_r[i]);
    end
  end

  // split into cell index and fraction, clamp at both grid edges
  always_comb begin
    for (int i = 0; i < NUM_AXIS; i++) begin
      if (s3_neg_r[i]) begin
        idx_nxt[i] = '0;
        f_nxt[i]   = '0;
        flg_nxt[i] = 1'b1;
      end else if (s3_p_r[i][63:32] >= 32'(N_AX[i] - 1)) begin
        idx_nxt[i] = IDX_W'(N_AX[i] - 2);
        f_nxt[i]   = FRAC_ONE;
        flg_nxt[i] = 1'b1;
      end else begin
        idx_nxt[i] = s3_p_r[i][32+IDX_W-1:32];
        f_nxt[i]   = {1'b0, s3_p_r[i][31:16]};
        flg_nxt[i] = 1'b0;
      end
    end
  end

  // corner addresses, wrapped to the grid depth
  always_comb begin
    for (int c = 0; c < NUM_CORNER; c++) begin
      addr_nxt[c] = ((ADDR_W'(s4_idx_r[0]) + ADDR_W'((c >> 2) & 1)) * ADDR_W'(N_DIST1)
                     + ADDR_W'(s4_idx_r[1]) + ADDR_W'((c >> 1) & 1)) * ADDR_W'(N_DIST2)
                    + ADDR_W'(s4_idx_r[2]) + ADDR_W'(c & 1);
    end
  end

  // valid bits; write requests leave after the grid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 9; k++) begin
        if (rdy[k]) begin
          if (k == 6) begin
            v_r[k] <= v_r[5] && (mode_r[5] == MODE_LOOKUP);
          end else begin
            v_r[k] <= v_r[k-1];
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      mode_r[1] <= in_mode;
      eidx_r[1] <= in_entry_index;
      comp_r[1] <= in_component;
      word_r[1] <= in_table_word;
      s1_x_r[0] <= in_angle;
      s1_x_r[1] <= in_dist1;
      s1_x_r[2] <= in_dist2;
    end
    for (int k = 2; k <= 5; k++) begin
      if (rdy[k]) begin
        mode_r[k] <= mode_r[k-1];
        eidx_r[k] <= eidx_r[k-1];
        comp_r[k] <= comp_r[k-1];
        word_r[k] <= word_r[k-1];
      end
    end
    if (rdy[2]) begin
      for (int i = 0; i < NUM_AXIS; i++) begin
        s2_d_r[i]   <= d_nxt[i][31:0];
        s2_neg_r[i] <= d_nxt[i][32];
      end
    end
    if (rdy[3]) begin
      s3_p_r   <= p_nxt;
      s3_neg_r <= s2_neg_r;
    end
    if (rdy[4]) begin
      s4_idx_r <= idx_nxt;
      s4_f_r   <= f_nxt;
      s4_flg_r <= flg_nxt;
    end
    if (rdy[5]) begin
      s5_addr_r <= addr_nxt;
      s5_f_r    <= s4_f_r;
      s5_flg_r  <= s4_flg_r;
    end
    if (rdy[6]) begin
      s6_f_r   <= s5_f_r;
      s6_flg_r <= s5_flg_r;
    end
    if (rdy[7]) begin
      for (int w = 0; w < NUM_WORD; w++) begin
        for (int kj = 0; kj < 4; kj++) begin
          s7_a_r[w][kj] <= lerp_a(s6_rd_r[w][kj*2], s6_rd_r[w][kj*2+1], s6_f_r[2]);
        end
      end
      s7_f1_r  <= s6_f_r[1];
      s7_fa_r  <= s6_f_r[0];
      s7_flg_r <= s6_flg_r;
    end
    if (rdy[8]) begin
      for (int w = 0; w < NUM_WORD; w++) begin
        for (int k = 0; k < 2; k++) begin
          s8_b_r[w][k] <= lerp_b(s7_a_r[w][k*2], s7_a_r[w][k*2+1], s7_f1_r);
        end
      end
      s8_fa_r  <= s7_fa_r;
      s8_flg_r <= s7_flg_r;
    end
    if (rdy[9]) begin
      for (int w = 0; w < NUM_WORD; w++) begin
        s9_res_r[w] <= lerp_c(s8_b_r[w][0], s8_b_r[w][1], s8_fa_r);
      end
      s9_flg_r <= s8_flg_r;
    end
  end

  // grid: one replica per corner, each written by every write request
  logic [31:0] grid_mem [NUM_CORNER][NUM_WORD][GRID_DEPTH];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int c = 0; c < NUM_CORNER; c++) begin
        for (int w = 0; w < NUM_WORD; w++) begin
          s6_rd_r[w][c] <= grid_mem[c][w][s5_addr_r[c]];
        end
      end
    end
    if (rdy[6] && v_r[5] && (mode_r[5] == MODE_WRITE)) begin
      for (int c = 0; c < NUM_CORNER; c++) begin
        grid_mem[c][comp_r[5]][eidx_r[5]] <= word_r[5];
      end
    end
  end

  // outputs
  assign out_valid       = v_r[9];
  assign out_energy      = s9_res_r[0];
  assign out_force_angle = s9_res_r[1];
  assign out_force_dist1 = s9_res_r[2];
  assign out_force_dist2 = s9_res_r[3];
  assign out_clamp_flags = s9_flg_r;

  // a stalled input means the first stage is holding a request
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v_r[1])
    else $error("input stalled with empty first stage");

  // write requests never reach the blend stages
  a_write_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && rdy[6] && mode_r[5] == MODE_WRITE) |=> !v_r[6])
    else $error("write request produced a result");

  // clamped angle sits on an edge cell with an edge fraction
  a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && s4_flg_r[0]) |->
      ((s4_idx_r[0] == '0 && s4_f_r[0] == '0) ||
       (s4_idx_r[0] == IDX_W'(N_ANGLE - 2) && s4_f_r[0] == FRAC_ONE)))
    else $error("angle clamp inconsistent");

  // fractions never exceed one
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (s4_f_r[0] <= FRAC_ONE && s4_f_r[1] <= FRAC_ONE &&
                s4_f_r[2] <= FRAC_ONE))
    else $error("fraction out of range");

endmodule

// ===== tb/tb_trilinear_table_lookup.sv =====
// ----------------------------------------------------------------------------
// tb_trilinear_table_lookup
// Self-checking bench for the trilinear table lookup. The origin and far
// corner cells are loaded first; every later lookup first fills any corner
// word it would read that was never written. Directed, configuration-sweep
// and random requests run with random idle bursts on both channels, but for
// a last quiet random block. Each lookup result is checked against an
// in-bench blend of the bench's own copy of the grid.
// ----------------------------------------------------------------------------
module tb_trilinear_table_lookup;
  import trilut_pkg::*;

  localparam int unsigned NA = N_ANGLE_DEF;
  localparam int unsigned N1 = N_DIST1_DEF;
  localparam int unsigned N2 = N_DIST2_DEF;
  localparam int unsigned DRAIN_CYC = 14;

  // table word selectors
  localparam logic [1:0] COMP_ENERGY = 2'd0;
  localparam logic [1:0] COMP_FANGLE = 2'd1;
  localparam logic [1:0] COMP_FDIST1 = 2'd2;
  localparam logic [1:0] COMP_FDIST2 = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = MODE_WRITE;
  logic [11:0]        in_entry_index = '0;
  logic [1:0]         in_component = COMP_ENERGY;
  logic signed [31:0] in_table_word = '0;
  logic signed [31:0] in_angle = '0;
  logic signed [31:0] in_dist1 = '0;
  logic signed [31:0] in_dist2 = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_energy;
  logic signed [31:0] out_force_angle;
  logic signed [31:0] out_force_dist1;
  logic signed [31:0] out_force_dist2;
  logic [2:0]         out_clamp_flags;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = CFG_ANGLE_LOW;
  logic [31:0]        cfg_wdata = '0;

  typedef struct {
    logic [31:0] word [4];
    logic [2:0]  flags;
  } blend_t;

  // bench copy of grid and registers
  logic [31:0] grid_copy [4][GRID_DEPTH];
  bit          filled [4][GRID_DEPTH];
  logic [31:0] low_reg [3];
  logic [31:0] inv_reg [3];
  logic [31:0] coord_span [3];

  blend_t pending_blends [$];
  int     mismatches = 0;
  bit     quiet = 1'b0;
  int     stall_left = 0;

  trilinear_table_lookup dut (.*);

  always #2 clk = ~clk;

  // map one coordinate onto an axis: cell index, 17-bit fraction, clamp flag
  function automatic bit axis_pos(logic [31:0] x, int ax, int unsigned n,
                                  output int idx, output longint frac);
    longint      d;
    logic [63:0] p;
    d = longint'($signed(x)) - longint'($signed(low_reg[ax]));
    if (d < 0) begin
      idx = 0;
      frac = 0;
      return 1'b1;
    end
    p = d[63:0] * {32'b0, inv_reg[ax]};
    if (p[63:32] >= n - 1) begin
      idx = n - 2;
      frac = 65536;
      return 1'b1;
    end
    idx = int'(p[63:32]);
    frac = longint'(p[31:16]);
    return 1'b0;
  endfunction

  // flat grid address of one point, wrapped to the grid depth
  function automatic int grid_addr(int ia, int i1, int i2);
    return int'(((ia * N1 + i1) * N2 + i2) & (GRID_DEPTH - 1));
  endfunction

  function automatic logic [31:0] grid_at(int c, int ia, int i1, int i2);
    return grid_copy[c][grid_addr(ia, i1, i2)];
  endfunction

  function automatic logic [31:0] corner_blend(int c, int ia, int i1, int i2,
                                               longint fa, longint f1, longint f2);
    longint a [2];
    longint b [2];
    longint acc;
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++)
        a[j] = longint'($signed(grid_at(c, ia + k, i1 + j, i2))) * (65536 - f2)
             + longint'($signed(grid_at(c, ia + k, i1 + j, i2 + 1))) * f2;
      b[k] = (a[0] * (65536 - f1) + a[1] * f1 + 32768) >>> 16;
    end
    acc = (b[0] * (65536 - fa) + b[1] * fa + 64'sh8000_0000) >>> 32;
    if (acc > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (acc < -64'sh8000_0000) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  // apply one accepted request to the bench grid or queue its blend
  function automatic void predict_request(logic mode, logic [11:0] e, logic [1:0] c,
                                          logic [31:0] w, logic [31:0] a,
                                          logic [31:0] d1, logic [31:0] d2);
    blend_t r;
    int     ia, i1, i2;
    longint fa, f1, f2;
    if (mode == MODE_WRITE) begin
      grid_copy[c][e] = w;
      filled[c][e] = 1'b1;
      return;
    end
    r.flags[0] = axis_pos(a, 0, NA, ia, fa);
    r.flags[1] = axis_pos(d1, 1, N1, i1, f1);
    r.flags[2] = axis_pos(d2, 2, N2, i2, f2);
    for (int k = 0; k < 4; k++) r.word[k] = corner_blend(k, ia, i1, i2, fa, f1, f2);
    pending_blends.push_back(r);
  endfunction

  // table word, mostly small, sometimes any value
  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  // send one request, with an optional idle burst first
  task automatic send_req(logic mode, logic [11:0] e, logic [1:0] c, logic [31:0] w,
                          logic [31:0] a, logic [31:0] d1, logic [31:0] d2);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_entry_index <= e;
    in_component <= c;
    in_table_word <= w;
    in_angle <= a;
    in_dist1 <= d1;
    in_dist2 <= d2;
    do @(posedge clk); while (in_stall);
    predict_request(mode, e, c, w, a, d1, d2);
  endtask

  task automatic write_word(logic [11:0] e, logic [1:0] c, logic [31:0] w);
    send_req(MODE_WRITE, e, c, w, $urandom, $urandom, $urandom);
  endtask

  // fill every corner word the lookup will read, then send the lookup
  task automatic lookup(logic [31:0] a, logic [31:0] d1, logic [31:0] d2);
    int     ia, i1, i2, e;
    longint fa, f1, f2;
    void'(axis_pos(a, 0, NA, ia, fa));
    void'(axis_pos(d1, 1, N1, i1, f1));
    void'(axis_pos(d2, 2, N2, i2, f2));
    for (int k = 0; k < 8; k++) begin
      e = grid_addr(ia + (k >> 2), i1 + ((k >> 1) & 1), i2 + (k & 1));
      for (int c = 0; c < 4; c++)
        if (!filled[c][e]) write_word(12'(e), 2'(c), rand_word());
    end
    send_req(MODE_LOOKUP, 12'($urandom), 2'($urandom), $urandom, a, d1, d2);
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // write all six axis registers; only called while drained
  task automatic set_axes(logic [31:0] lo [3], logic [31:0] inv [3], logic [31:0] span [3]);
    for (int ax = 0; ax < 3; ax++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= ax == 0 ? CFG_ANGLE_LOW : ax == 1 ? CFG_DIST1_LOW : CFG_DIST2_LOW;
      cfg_wdata <= lo[ax];
      @(posedge clk);
      cfg_index <= ax == 0 ? CFG_ANGLE_INV_STEP :
                   ax == 1 ? CFG_DIST1_INV_STEP : CFG_DIST2_INV_STEP;
      cfg_wdata <= inv[ax];
      low_reg[ax] = lo[ax];
      inv_reg[ax] = inv[ax];
      coord_span[ax] = span[ax];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // coordinate mostly near the first grid points, sometimes anywhere
  function automatic logic [31:0] rand_coord(int ax);
    if ($urandom_range(0, 4) == 0) return $urandom;
    return low_reg[ax] + $urandom_range(0, coord_span[ax]) - 32'($urandom_range(0, 1));
  endfunction

  // load the origin cell and the far corner cell
  task automatic test_load_grid();
    for (int k = 0; k < 8; k++)
      for (int c = 0; c < 4; c++) begin
        write_word(12'(grid_addr(k >> 2, (k >> 1) & 1, k & 1)), 2'(c), rand_word());
        write_word(12'(grid_addr(int'(NA) - 2 + (k >> 2), int'(N1) - 2 + ((k >> 1) & 1),
                                 int'(N2) - 2 + (k & 1))), 2'(c), rand_word());
      end
    drain();
  endtask

  task automatic test_directed();
    write_word(12'd0, COMP_ENERGY, 32'h7FFF_FFFF);
    write_word(12'd1, COMP_ENERGY, 32'h8000_0000);
    write_word(12'd16, COMP_FANGLE, 32'h7FFF_FFFF);
    write_word(12'd256, COMP_FDIST1, 32'h8000_0000);
    write_word(12'd4095, COMP_FDIST2, 32'h7FFF_FFFF);
    write_word(12'd273, COMP_FDIST2, 32'h0000_0000);
    lookup(32'h0, 32'h0, 32'h0);
    lookup(32'h0, 32'h0, 32'h0000_8000);
    lookup(32'h0000_8000, 32'h0000_FFFF, 32'h0000_0001);
    lookup(32'h0000_3000, 32'h0001_4000, 32'h0000_C000);
    lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    lookup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    lookup(32'hFFFF_FFFF, 32'h0000_8000, 32'h000F_0000);
    lookup(32'h000E_FFFF, 32'h000F_0000, 32'h000E_8000);
    lookup(32'h0005_4321, 32'h0009_8765, 32'h000C_ABCD);
    drain();
  endtask

  task automatic random_block(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3)
        write_word(12'($urandom), 2'($urandom), $urandom_range(0, 7) == 0 ?
                   ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom);
      else
        lookup(rand_coord(0), rand_coord(1), rand_coord(2));
    end
  endtask

  // several axis settings, extremes among them
  task automatic test_config_sweep();
    set_axes('{32'hFFF8_0000, 32'h0000_C000, 32'h0000_0000},
             '{32'h0000_8000, 32'h0002_0000, 32'h0001_0000},
             '{32'h0004_0000, 32'h0001_0000, 32'h0002_0000});
    random_block(50);
    drain();
    set_axes('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
             '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001},
             '{32'h0000_0003, 32'h0000_0010, 32'hFFFF_FFFF});
    random_block(50);
    lookup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    lookup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();
    set_axes('{32'h0000_0000, 32'h8000_0000, 32'hFFFF_0000},
             '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0010_0000},
             '{32'h0001_0000, 32'h0000_0003, 32'h0000_2000});
    random_block(50);
    drain();
  endtask

  task automatic test_random();
    set_axes('{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
             '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
             '{32'h0002_0000, 32'h0002_0000, 32'h0002_0000});
    random_block(350);
    quiet = 1'b1;
    random_block(100);
    drain();
  endtask

  // result checking and receiver stall bursts
  always @(posedge clk) begin
    blend_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blends.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected lookup result at %0t", $realtime);
      end else begin
        r = pending_blends.pop_front();
        if (out_energy !== r.word[0] || out_force_angle !== r.word[1] ||
            out_force_dist1 !== r.word[2] || out_force_dist2 !== r.word[3] ||
            out_clamp_flags !== r.flags) begin
          mismatches++;
          if (mismatches <= 10)
            $display("lookup mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                     r.word[0], r.word[1], r.word[2], r.word[3], r.flags,
                     out_energy, out_force_angle, out_force_dist1, out_force_dist2,
                     out_clamp_flags);
        end
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    for (int ax = 0; ax < 3; ax++) begin
      low_reg[ax] = '0;
      inv_reg[ax] = INV_STEP_RESET;
      coord_span[ax] = 32'h0002_0000;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_load_grid();
    test_directed();
    test_config_sweep();
    test_random();
    if (mismatches == 0 && pending_blends.size() == 0) begin
      $display("** trilinear_table_lookup: PASSED **");
    end else begin
      $display("** trilinear_table_lookup: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("** trilinear_table_lookup: FAILED **");
    $finish;
  end

endmodule
